[hdl/stsearch_pkg.sv]
// shared types and constants of the sorted table search block
package stsearch_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_WIDTH_DEF   = 32;

  localparam int MODE_W     = 2;
  localparam int POS_W      = 8;
  localparam int KEY_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int COUNT_W    = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXACT = 2'd1,
    MODE_CEIL  = 2'd2,
    MODE_FLOOR = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT    = 2'd0,
    REG_COMPARE_SIGNED = 2'd1,
    REG_SPARE2         = 2'd2,
    REG_SPARE3         = 2'd3
  } cfg_reg_e;

  // control bits that travel with each word down the pipeline
  typedef struct packed {
    logic  valid;
    mode_e mode;
    logic  probe_ok;
    logic  eq;
  } ctl_t;

endpackage

[hdl/stsearch_if.sv]
// channel interfaces: item input, result output, configuration write
interface stsearch_in_if;
  import stsearch_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position_in;
  logic [KEY_W-1:0]  key;
  modport source (output valid, mode, position_in, key, input ready);
  modport sink   (input valid, mode, position_in, key, output ready);
endinterface

interface stsearch_out_if;
  import stsearch_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position_out;
  modport source (output valid, found, position_out, input ready);
  modport sink   (input valid, found, position_out, output ready);
endinterface

interface stsearch_cfg_if;
  import stsearch_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/stsearch_ram.sv]
// generic simple dual-port ram with registered read
module stsearch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/stsearch_probe.sv]
// one search stage: settle previous probe, issue next probe, own table copy
module stsearch_probe import stsearch_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int KW    = KEY_WIDTH_DEF,
  parameter int J     = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       signed_i,
  input  ctl_t                       ctl_i,
  input  logic [KW-1:0]              key_i,
  input  logic [POS_W-1:0]           pos_i,
  input  logic [$clog2(DEPTH):0]     n_i,
  input  logic [$clog2(DEPTH):0]     idx_i,
  input  logic [KW-1:0]              data_i,
  output ctl_t                       ctl_o,
  output logic [KW-1:0]              key_o,
  output logic [POS_W-1:0]           pos_o,
  output logic [$clog2(DEPTH):0]     n_o,
  output logic [$clog2(DEPTH):0]     idx_o,
  output logic [KW-1:0]              data_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int IW  = AW + 1;
  localparam int PSH = (J > 0) ? (AW - J + 1) : 0;
  localparam int SH  = (J <= AW) ? (AW - J) : 0;
  localparam logic [KW-1:0] SIGN = KW'(1) << (KW - 1);

  ctl_t            ctl_d, ctl_q;
  logic [IW-1:0]   idx_d, idx_q;
  logic [KW-1:0]   key_q;
  logic [POS_W-1:0] pos_q;
  logic [IW-1:0]   n_q;
  logic [KW-1:0]   ev;
  logic            cond;
  logic [IW-1:0]   cand;
  logic [AW-1:0]   raddr;
  logic [AW+POS_W-1:0] pos_x;
  logic            wr_en;

  // settle the probe read by the previous stage, then issue the next probe
  always_comb begin
    ev    = data_i ^ (signed_i ? SIGN : '0);
    cond  = (ctl_i.mode == MODE_FLOOR) ? (ev > key_i) : (ev >= key_i);
    ctl_d = ctl_i;
    idx_d = idx_i;
    if ((J > 0) && ctl_i.probe_ok) begin
      if (!cond) begin
        idx_d = idx_i | (IW'(1) << PSH);
      end else begin
        ctl_d.eq = (ev == key_i);
      end
    end
    // next candidate count and its probe address
    cand           = idx_d | (IW'(1) << SH);
    raddr          = AW'(cand - IW'(1));
    ctl_d.probe_ok = (J <= AW) && (cand <= n_i);
  end

  assign pos_x = {{AW{1'b0}}, pos_i};
  assign wr_en = en_i && ctl_i.valid && (ctl_i.mode == MODE_WRITE) &&
                 ({24'd0, pos_i} < 32'(DEPTH));

  // table copy for this stage
  if (J <= AW) begin : g_ram
    stsearch_ram #(
      .WIDTH(KW),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en),
      .waddr_i(pos_x[AW-1:0]),
      .wdata_i(key_i),
      .re_i   (en_i),
      .raddr_i(raddr),
      .rdata_o(data_o)
    );
  end else begin : g_no_ram
    assign data_o = '0;
  end

  // stage control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  // stage payload register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_i;
      pos_q <= pos_i;
      n_q   <= n_i;
      idx_q <= idx_d;
    end
  end

  assign ctl_o = ctl_q;
  assign key_o = key_q;
  assign pos_o = pos_q;
  assign n_o   = n_q;
  assign idx_o = idx_q;

endmodule

[hdl/sorted_table_exact_ceiling_floor_search_top.sv]
// top level of the sorted key table with exact, ceiling and floor search
//
//   channel  dir  carries                         handshake
//   in_i     in   mode, position_in, key           valid/ready
//   out_i    out  found, position_out              valid/ready
//   cfg_i    in   index, data                      valid/ready, always ready
//
// a word enters every cycle unless the output stalls; one pipeline stage per
// halving probe, each reading its own copy of the table, then a settling stage
// and the output register. writes give no result and update each copy as they
// pass. reset clears valid bits and sets the config registers; the table is
// undefined until written. a stall freezes the whole pipeline, nothing is lost.
module sorted_table_exact_ceiling_floor_search_top import stsearch_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  stsearch_in_if.sink    in_i,
  stsearch_out_if.source out_i,
  stsearch_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = AW + 1;
  localparam int NS = AW + 3;
  localparam logic [KEY_WIDTH-1:0] SIGN = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

  logic [COUNT_W-1:0] entry_count_q;
  logic               signed_q;
  logic [IW-1:0]      nc;
  logic [IW+COUNT_W-1:0] ec_x;
  logic               en;

  ctl_t                 c_s [NS];
  logic [KEY_WIDTH-1:0] k_s [NS];
  logic [POS_W-1:0]     p_s [NS];
  logic [IW-1:0]        n_s [NS];
  logic [IW-1:0]        i_s [NS];
  logic [KEY_WIDTH-1:0] d_s [NS];

  logic [KEY_WIDTH+KEY_W-1:0] key_x;
  logic [KEY_WIDTH-1:0]       key_raw;

  logic                 out_valid_q, out_valid_d;
  logic                 found_q, found_d;
  logic [POS_W-1:0]     opos_q, opos_d;
  logic [IW-1:0]        pidx;
  logic [IW+POS_W-1:0]  pidx_x;
  logic                 lt;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= COUNT_W'(1);
      signed_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_ENTRY_COUNT:    entry_count_q <= cfg_i.data[COUNT_W-1:0];
        REG_COMPARE_SIGNED: signed_q      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // searched count limited to the table depth
  assign ec_x = {{IW{1'b0}}, entry_count_q};
  assign nc = ({23'd0, entry_count_q} > 32'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH)
                                                           : ec_x[IW-1:0];

  // pipeline moves whenever the output register can take a word
  assign en         = !out_valid_q || out_i.ready;
  assign in_i.ready = en;

  // entry of a word: map search keys into unsigned order
  assign key_x   = {{KEY_WIDTH{1'b0}}, in_i.key};
  assign key_raw = key_x[KEY_WIDTH-1:0];
  always_comb begin
    c_s[0].valid    = in_i.valid;
    c_s[0].mode     = mode_e'(in_i.mode);
    c_s[0].probe_ok = 1'b0;
    c_s[0].eq       = 1'b0;
    k_s[0] = (mode_e'(in_i.mode) != MODE_WRITE && signed_q) ? (key_raw ^ SIGN)
                                                            : key_raw;
    p_s[0] = in_i.position_in;
    n_s[0] = nc;
    i_s[0] = '0;
    d_s[0] = '0;
  end

  // probe stages, the last one only settles
  for (genvar j = 0; j <= AW + 1; j++) begin : g_stage
    stsearch_probe #(
      .DEPTH(TABLE_DEPTH),
      .KW   (KEY_WIDTH),
      .J    (j)
    ) u_probe (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .signed_i(signed_q),
      .ctl_i   (c_s[j]),
      .key_i   (k_s[j]),
      .pos_i   (p_s[j]),
      .n_i     (n_s[j]),
      .idx_i   (i_s[j]),
      .data_i  (d_s[j]),
      .ctl_o   (c_s[j+1]),
      .key_o   (k_s[j+1]),
      .pos_o   (p_s[j+1]),
      .n_o     (n_s[j+1]),
      .idx_o   (i_s[j+1]),
      .data_o  (d_s[j+1])
    );
  end

  // result formatting from the settled count
  always_comb begin
    lt      = i_s[NS-1] < n_s[NS-1];
    pidx    = i_s[NS-1];
    found_d = 1'b0;
    case (c_s[NS-1].mode)
      MODE_EXACT: found_d = lt && c_s[NS-1].eq;
      MODE_CEIL:  found_d = lt;
      MODE_FLOOR: begin
        found_d = (i_s[NS-1] != '0);
        pidx    = i_s[NS-1] - IW'(1);
      end
      default:    found_d = 1'b0;
    endcase
    pidx_x      = {{POS_W{1'b0}}, pidx};
    opos_d      = found_d ? pidx_x[POS_W-1:0] : '0;
    out_valid_d = c_s[NS-1].valid && (c_s[NS-1].mode != MODE_WRITE);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      found_q <= found_d;
      opos_q  <= opos_d;
    end
  end

  assign out_i.valid        = out_valid_q;
  assign out_i.found        = found_q;
  assign out_i.position_out = opos_q;

  // a new result only comes from a settled search word
  a_result_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(c_s[NS-1].valid && c_s[NS-1].mode != MODE_WRITE))
    else $error("result without a search word");

  // a stall freezes the pipeline control
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(c_s[1]) && $stable(c_s[NS-1]))
    else $error("pipeline moved during stall");

  // a found position lies inside the searched range
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && found_q |-> ({{IW{1'b0}}, opos_q} < {{POS_W{1'b0}}, nc}))
    else $error("found position outside searched range");

endmodule
